@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file plm_check.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, quiet during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Implication checked in the next cycle, quiet during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Checked in the next cycle, also across reset.
`define ASSERT_NXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: post-reset condition");

`endif

@@ rtl/core/plm_pkg.sv @@
// Package for the port link-state machine: state and op codes, widths,
// transition table and the step result struct. No dependencies.
`timescale 1ns / 1ps

package plm_pkg;

  localparam int CountWidth = 32;

  // port states
  localparam logic [2:0] StOff    = 3'd0;
  localparam logic [2:0] StDown   = 3'd1;
  localparam logic [2:0] StMacUp  = 3'd2;
  localparam logic [2:0] StLinkUp = 3'd3;
  localparam logic [2:0] StUp     = 3'd4;
  localparam logic [2:0] StFault  = 3'd5;

  // events
  localparam logic [2:0] EvMacDn  = 3'd0;
  localparam logic [2:0] EvMacUp  = 3'd1;
  localparam logic [2:0] EvLinkDn = 3'd2;
  localparam logic [2:0] EvLinkUp = 3'd3;
  localparam logic [2:0] EvBusChg = 3'd4;

  // table actions
  localparam logic [3:0] OpNop = 4'd0;
  localparam logic [3:0] OpInv = 4'd1;
  localparam logic [3:0] OpMcu = 4'd2;
  localparam logic [3:0] OpMcd = 4'd3;
  localparam logic [3:0] OpLku = 4'd4;
  localparam logic [3:0] OpLkd = 4'd5;
  localparam logic [3:0] OpUld = 4'd6;
  localparam logic [3:0] OpUp  = 4'd7;
  localparam logic [3:0] OpBus = 4'd8;

  typedef struct packed {
    logic [2:0] state_next;
    logic [7:0] bus_next;
    logic       fault;
    logic       linkup;
    logic       linkdn;
    logic       hostup;
    logic       hostdn;
    logic       buschg;
    logic       link_inc;
    logic       host_inc;
  } step_t;

  // 6x5 transition table; unknown states or events map to nop
  function automatic logic [3:0] trans_op(input logic [2:0] state,
                                          input logic [2:0] action);
    logic [3:0] op;
    op = OpNop;
    case (state)
      StOff, StDown: begin
        case (action)
          EvMacUp:  op = OpMcu;
          EvLinkUp: op = OpInv;
          default:  op = OpNop;
        endcase
      end
      StMacUp: begin
        case (action)
          EvMacDn:  op = OpMcd;
          EvMacUp:  op = OpInv;
          EvLinkUp: op = OpLku;
          default:  op = OpNop;
        endcase
      end
      StLinkUp: begin
        case (action)
          EvMacDn:  op = OpInv;
          EvMacUp:  op = OpInv;
          EvLinkDn: op = OpLkd;
          EvLinkUp: op = OpLku;
          EvBusChg: op = OpUp;
          default:  op = OpNop;
        endcase
      end
      StUp: begin
        case (action)
          EvMacDn:  op = OpInv;
          EvMacUp:  op = OpInv;
          EvLinkDn: op = OpUld;
          EvLinkUp: op = OpInv;
          EvBusChg: op = OpBus;
          default:  op = OpNop;
        endcase
      end
      StFault: begin
        case (action)
          EvMacDn: op = OpMcd;
          default: op = OpNop;
        endcase
      end
      default: op = OpNop;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/core/plm_if.sv @@
// Handshake interfaces for the event and result channels.
// Depends on nothing; widths follow the item fields.
`timescale 1ns / 1ps

interface plm_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_read;
  logic       gate_ok;

  modport source (output valid, action, bus_read, gate_ok, input ready);
  modport sink   (input valid, action, bus_read, gate_ok, output ready);
endinterface

interface plm_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  new_state;
  logic        fault_raised;
  logic        linkup_note;
  logic        linkdn_note;
  logic        hostup_note;
  logic        hostdn_note;
  logic        buschg_note;
  logic [31:0] link_count_out;
  logic [31:0] host_count_out;
  logic [31:0] fault_count_out;
  logic [7:0]  bus_out;

  modport source (output valid, new_state, fault_raised, linkup_note, linkdn_note,
                  hostup_note, hostdn_note, buschg_note, link_count_out,
                  host_count_out, fault_count_out, bus_out, input ready);
  modport sink   (input valid, new_state, fault_raised, linkup_note, linkdn_note,
                  hostup_note, hostdn_note, buschg_note, link_count_out,
                  host_count_out, fault_count_out, bus_out, output ready);
  modport mon    (input valid, ready, new_state, fault_raised, linkup_note,
                  linkdn_note, hostup_note, hostdn_note, buschg_note,
                  link_count_out, host_count_out, fault_count_out, bus_out);
endinterface

@@ rtl/core/pcie_port_link_state_machine.sv @@
// Port link-state machine top level.
// Path: an accepted event is held in the input register, then in the result register.
// Throughput: one event per cycle while the result is taken; the state and counter
// update is combinational between the input register and the result register.
// Reset (rst, synchronous): state off, bus and all counts zero, both stages empty.
// Depends on plm_pkg, plm_if, plm_step.
`timescale 1ns / 1ps

module pcie_port_link_state_machine (
  input logic       clk,
  input logic       rst,
  plm_evt_if.sink   evt,
  plm_res_if.source res
);

  localparam int CW = plm_pkg::CountWidth;

  // input stage
  logic       evt_vld;
  logic [2:0] evt_action;
  logic [7:0] evt_bus;
  logic       evt_gate;

  // block state
  logic [2:0]    port_state;
  logic [7:0]    secondary_bus;
  logic [CW-1:0] link_ups;
  logic [CW-1:0] host_ups;
  logic [CW-1:0] fault_total;
  logic [CW-1:0] link_ups_next;
  logic [CW-1:0] host_ups_next;
  logic [CW-1:0] fault_total_next;

  // result stage
  logic res_vld;

  logic           adv;
  plm_pkg::step_t step;

  assign adv       = evt_vld && (!res_vld || res.ready);
  assign evt.ready = !evt_vld || adv;
  assign res.valid = res_vld;

  plm_step u_step (
    .state    (port_state),
    .bus      (secondary_bus),
    .action   (evt_action),
    .bus_read (evt_bus),
    .gate_ok  (evt_gate),
    .step     (step)
  );

  assign link_ups_next    = link_ups    + {{(CW-1){1'b0}}, step.link_inc};
  assign host_ups_next    = host_ups    + {{(CW-1){1'b0}}, step.host_inc};
  assign fault_total_next = fault_total + {{(CW-1){1'b0}}, step.fault};

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_vld <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      evt_vld <= 1'b1;
    end else if (adv) begin
      evt_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      evt_action <= evt.action;
      evt_bus    <= evt.bus_read;
      evt_gate   <= evt.gate_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_state    <= plm_pkg::StOff;
      secondary_bus <= 8'd0;
      link_ups      <= '0;
      host_ups      <= '0;
      fault_total   <= '0;
      res_vld       <= 1'b0;
    end else begin
      if (adv) begin
        port_state    <= step.state_next;
        secondary_bus <= step.bus_next;
        link_ups      <= link_ups_next;
        host_ups      <= host_ups_next;
        fault_total   <= fault_total_next;
        res_vld       <= 1'b1;
      end else if (res.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  // result payload; counts report the low 32 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      res.new_state       <= step.state_next;
      res.fault_raised    <= step.fault;
      res.linkup_note     <= step.linkup;
      res.linkdn_note     <= step.linkdn;
      res.hostup_note     <= step.hostup;
      res.hostdn_note     <= step.hostdn;
      res.buschg_note     <= step.buschg;
      res.link_count_out  <= 32'(link_ups_next);
      res.host_count_out  <= 32'(host_ups_next);
      res.fault_count_out <= 32'(fault_total_next);
      res.bus_out         <= step.bus_next;
    end
  end

endmodule

@@ rtl/core/plm_step.sv @@
// Per-event decode: table lookup and action for one event.
// Depends on plm_pkg (codes, trans_op, step_t).
`timescale 1ns / 1ps

module plm_step (
  input  logic [2:0]     state,
  input  logic [7:0]     bus,
  input  logic [2:0]     action,
  input  logic [7:0]     bus_read,
  input  logic           gate_ok,
  output plm_pkg::step_t step
);

  logic [3:0] op;

  assign op = plm_pkg::trans_op(state, action);

  always_comb begin
    step            = '0;
    step.state_next = state;
    step.bus_next   = bus;
    case (op)
      plm_pkg::OpInv: begin
        step.fault      = 1'b1;
        step.state_next = plm_pkg::StFault;
      end
      plm_pkg::OpMcu: step.state_next = plm_pkg::StMacUp;
      plm_pkg::OpMcd: step.state_next = plm_pkg::StDown;
      plm_pkg::OpLku: begin
        if (!gate_ok) begin
          step.fault      = 1'b1;
          step.state_next = plm_pkg::StFault;
        end else begin
          step.state_next = plm_pkg::StLinkUp;
          step.bus_next   = bus_read;
          step.link_inc   = 1'b1;
          step.linkup     = 1'b1;
        end
      end
      plm_pkg::OpLkd: begin
        step.state_next = plm_pkg::StMacUp;
        step.linkdn     = 1'b1;
      end
      plm_pkg::OpUld: begin
        step.state_next = plm_pkg::StMacUp;
        step.bus_next   = 8'd0;
        step.hostdn     = 1'b1;
        step.linkdn     = 1'b1;
      end
      plm_pkg::OpUp: begin
        step.state_next = plm_pkg::StUp;
        step.bus_next   = bus_read;
        step.buschg     = (bus_read != 8'd0) && (bus_read != bus);
        step.host_inc   = 1'b1;
        step.hostup     = 1'b1;
      end
      plm_pkg::OpBus: begin
        step.bus_next = bus_read;
        step.buschg   = (bus_read != 8'd0) && (bus_read != bus);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/plm_check.sv @@
// Port-level checker for the link-state machine, bound to the top level.
// Depends on plm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plm_check (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  new_state,
  input logic        fault_raised,
  input logic        linkdn_note,
  input logic        hostup_note,
  input logic        hostdn_note,
  input logic [31:0] fault_count_out,
  input logic [7:0]  bus_out
);

  logic res_out;
  logic stall;

  assign res_out = res_valid && res_ready;
  assign stall   = res_valid && !res_ready;

  // any recorded fault leaves the port in fault
  `ASSERT_IMP(a_fault_state, clk, rst, res_out && fault_raised, new_state == plm_pkg::StFault)
  // host down only comes from up, with link down and bus cleared
  `ASSERT_IMP(a_hostdn, clk, rst, res_out && hostdn_note, linkdn_note && new_state == plm_pkg::StMacUp && bus_out == 8'd0)
  // host up lands in up and never with a fault
  `ASSERT_IMP(a_hostup, clk, rst, res_out && hostup_note, new_state == plm_pkg::StUp && !fault_raised)
  // a stalled result holds
  `ASSERT_NXT(a_stall, clk, rst, stall, res_valid && $stable(new_state) && $stable(fault_count_out))
  // no result right after reset
  `ASSERT_NXT_RST(a_rst, clk, rst, !res_valid)

endmodule

bind pcie_port_link_state_machine plm_check u_plm_check (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .new_state       (res.new_state),
  .fault_raised    (res.fault_raised),
  .linkdn_note     (res.linkdn_note),
  .hostup_note     (res.hostup_note),
  .hostdn_note     (res.hostdn_note),
  .fault_count_out (res.fault_count_out),
  .bus_out         (res.bus_out)
);
